// File: sv/bfdh_pkg.sv
// shared constants for the bloom filter bit store
`default_nettype none
package bfdh_pkg;

    // fixed field widths
    localparam int HASH_W  = 64;
    localparam int COUNT_W = 32;
    localparam int SIZE_W  = 5;
    localparam int PROBE_W = 6;

    // storage word
    localparam int WORD_BITS  = 64;
    localparam int WORD_SHIFT = 6;

    // size limits and parameter defaults
    localparam int MIN_SIZE_LOG2     = 9;
    localparam int DEF_MAX_SIZE_LOG2 = 16;
    localparam int DEF_MAX_PROBES    = 32;

    // register reset values
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(9);
    localparam logic [PROBE_W-1:0] PROBE_RESET = PROBE_W'(7);

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // commands
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam logic REG_SIZE_LOG2   = 1'b0;
    localparam logic REG_PROBE_COUNT = 1'b1;

endpackage
`default_nettype wire

// File: sv/bfdh_req_if.sv
// input channel: command and key digest halves
`default_nettype none
interface bfdh_req_if import bfdh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [HASH_W-1:0] hash_lo;
    logic [HASH_W-1:0] hash_hi;

    modport source (output valid, output cmd, output hash_lo, output hash_hi, input ready);
    modport sink   (input valid, input cmd, input hash_lo, input hash_hi, output ready);
endinterface
`default_nettype wire

// File: sv/bfdh_rsp_if.sv
// result channel: presence flag and item count
`default_nettype none
interface bfdh_rsp_if import bfdh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               present;
    logic [COUNT_W-1:0] item_count;

    modport source (output valid, output present, output item_count, input ready);
    modport sink   (input valid, input present, input item_count, output ready);
endinterface
`default_nettype wire

// File: sv/bfdh_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module bfdh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: sv/bloom_filter_double_hash.sv
// bloom filter bit store with double-hashed probes over a word ram
// An accepted beat probes bits (hash_lo + hash_hi*i) mod 2^size_log2 for i below
// probe_count, both clamped to their limits; an add sets them and counts the
// key, a query reports whether all were set, and each beat yields one result
// carrying the saturating key count. Probes walk the index by repeated addition
// of the stride and go to the bit ram one per cycle through its single read
// port; the read-modify-write of an add lands in the cycle after its read, with
// the previous write forwarded when two probes hit the same word. A new beat is
// taken only when idle, once the previous result is registered. After reset all
// 2^(MAX_SIZE_LOG2-6) ram words (1024 at the default) are swept to zero, during
// which no beat is accepted; configuration writes are taken throughout.
`default_nettype none
module bloom_filter_double_hash import bfdh_pkg::*; #(
    parameter int MAX_SIZE_LOG2 = DEF_MAX_SIZE_LOG2,
    parameter int MAX_PROBES    = DEF_MAX_PROBES
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready,
    bfdh_req_if.sink                   i_in,
    bfdh_rsp_if.source                 o_out
);

    localparam int IW    = MAX_SIZE_LOG2;
    localparam int AW    = MAX_SIZE_LOG2 - WORD_SHIFT;
    localparam int DEPTH = 1 << AW;
    localparam int PCW   = $clog2(MAX_PROBES + 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]           r_state;
    logic [AW-1:0]        r_clr_addr;
    logic [SIZE_W-1:0]    r_size_log2;
    logic [PROBE_W-1:0]   r_probe_count;
    logic [COUNT_W-1:0]   r_count;
    logic [COUNT_W-1:0]   n_count;
    logic [PCW-1:0]       r_left;
    logic                 r_s1_valid;
    logic                 r_wb_valid;
    logic                 r_out_valid;

    logic                 r_cmd;
    logic [IW-1:0]        r_idx;
    logic [IW-1:0]        r_stride;
    logic                 r_hit;
    logic [AW-1:0]        r_s1_word;
    logic [WORD_SHIFT-1:0] r_s1_bit;
    logic [AW-1:0]        r_wb_word;
    logic [WORD_BITS-1:0] r_wb_data;
    logic                 r_out_present;
    logic [COUNT_W-1:0]   r_out_count;

    logic [SIZE_W-1:0]    w_size;
    logic [PCW-1:0]       w_probes;
    logic [IW-1:0]        w_mask;
    logic [IW-1:0]        w_pidx;
    logic                 w_issue;
    logic                 w_accept;
    logic                 w_load;
    logic                 w_cfg_wr;
    logic                 w_reg_idx;
    logic [WORD_BITS-1:0] w_rdata;
    logic [WORD_BITS-1:0] w_word;
    logic [WORD_BITS-1:0] w_new;
    logic                 w_upd_we;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    logic [WORD_BITS-1:0] w_wdata;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_idx = paddr[2];

    always_comb begin
        unique case (w_reg_idx)
            REG_SIZE_LOG2:   prdata = APB_DATA_W'(r_size_log2);
            REG_PROBE_COUNT: prdata = APB_DATA_W'(r_probe_count);
            default:         prdata = '0;
        endcase
    end

    // effective size and probe count
    always_comb begin
        if (r_size_log2 < SIZE_W'(MIN_SIZE_LOG2)) begin
            w_size = SIZE_W'(MIN_SIZE_LOG2);
        end else if (r_size_log2 > SIZE_W'(MAX_SIZE_LOG2)) begin
            w_size = SIZE_W'(MAX_SIZE_LOG2);
        end else begin
            w_size = r_size_log2;
        end
        if ({1'b0, r_probe_count} > (PROBE_W + 1)'(MAX_PROBES)) begin
            w_probes = PCW'(MAX_PROBES);
        end else begin
            w_probes = PCW'(r_probe_count);
        end
        for (int k = 0; k < IW; k++) begin
            w_mask[k] = (k < int'(w_size));
        end
    end

    assign w_pidx   = r_idx & w_mask;
    assign w_issue  = (r_state == ST_RUN) && (r_left != '0);
    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);
    assign i_in.ready = (r_state == ST_IDLE);

    // second stage: forward last cycle's write to the same word
    assign w_word   = (r_wb_valid && (r_wb_word == r_s1_word)) ? r_wb_data : w_rdata;
    assign w_new    = w_word | (WORD_BITS'(1) << r_s1_bit);
    assign w_upd_we = r_s1_valid && (r_cmd == CMD_ADD);

    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr_addr;
            w_wdata = '0;
        end else begin
            w_we    = w_upd_we;
            w_waddr = r_s1_word;
            w_wdata = w_new;
        end
    end

    always_comb begin
        n_count = r_count;
        if ((r_cmd == CMD_ADD) && (r_count != COUNT_MAX)) begin
            n_count = r_count + COUNT_W'(1);
        end
    end

    bfdh_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_pidx[IW-1:WORD_SHIFT]),
        .o_rdata (w_rdata)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_size_log2   <= SIZE_RESET;
            r_probe_count <= PROBE_RESET;
            r_count       <= '0;
            r_left        <= '0;
            r_s1_valid    <= 1'b0;
            r_wb_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    REG_SIZE_LOG2:   r_size_log2   <= pwdata[SIZE_W-1:0];
                    REG_PROBE_COUNT: r_probe_count <= pwdata[PROBE_W-1:0];
                    default: ;
                endcase
            end
            r_s1_valid <= w_issue;
            r_wb_valid <= w_upd_we;
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_accept) begin
                        r_left  <= w_probes;
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (w_issue) begin
                        r_left <= r_left - PCW'(1);
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (w_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= i_in.cmd;
            r_idx    <= i_in.hash_lo[IW-1:0];
            r_stride <= i_in.hash_hi[IW-1:0];
            r_hit    <= 1'b1;
        end else begin
            if (w_issue) begin
                r_idx <= r_idx + r_stride;
            end
            if (r_s1_valid && (r_cmd == CMD_QUERY) && !w_word[r_s1_bit]) begin
                r_hit <= 1'b0;
            end
        end
        if (w_issue) begin
            r_s1_word <= w_pidx[IW-1:WORD_SHIFT];
            r_s1_bit  <= w_pidx[WORD_SHIFT-1:0];
        end
        r_wb_word <= r_s1_word;
        r_wb_data <= w_new;
        if (w_load) begin
            r_out_present <= (r_cmd == CMD_QUERY) ? r_hit : 1'b0;
            r_out_count   <= n_count;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.present    = r_out_present;
    assign o_out.item_count = r_out_count;

endmodule
`default_nettype wire

// File: verif/tb.sv
// testbench for the double-hashed bloom filter: directed and random keys checked against a shadow filter
`timescale 1ns / 100ps
module tb;
    import bfdh_pkg::*;

    typedef struct {
        logic              cmd;
        logic [HASH_W-1:0] lo;
        logic [HASH_W-1:0] hi;
    } key_beat_t;

    typedef struct {
        logic               present;
        logic [COUNT_W-1:0] count;
    } lookup_result_t;

    localparam int MAX_LOG2     = DEF_MAX_SIZE_LOG2;
    localparam int MAX_PRB      = DEF_MAX_PROBES;
    localparam int FILT_WORDS   = (1 << MAX_LOG2) / WORD_BITS;
    localparam int TARGET_ITEMS = 550;
    localparam int KEEP_KEYS    = 256;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bfdh_req_if req_if ();
    bfdh_rsp_if rsp_if ();

    bloom_filter_double_hash u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (req_if),
        .o_out   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // shadow of the filter and its registers
    logic [WORD_BITS-1:0] filt_bits [FILT_WORDS];
    logic [COUNT_W-1:0]   keys_added;
    logic [SIZE_W-1:0]    cfg_size;
    logic [PROBE_W-1:0]   cfg_probes;

    key_beat_t      keys_pending [$];
    key_beat_t      keys_kept [$];
    lookup_result_t results_due [$];
    int             errors     = 0;
    int unsigned    send_gap   = 0;
    int unsigned    stall_left = 0;
    bit             calm       = 1'b0;

    function automatic lookup_result_t hash_probe(key_beat_t k);
        lookup_result_t    r;
        int unsigned       size_eff;
        int unsigned       n_eff;
        logic [HASH_W-1:0] mask;
        logic [HASH_W-1:0] idx;
        logic [HASH_W-1:0] word;
        size_eff = 32'(cfg_size);
        if (size_eff < MIN_SIZE_LOG2)
            size_eff = MIN_SIZE_LOG2;
        if (size_eff > MAX_LOG2)
            size_eff = MAX_LOG2;
        n_eff = (cfg_probes > PROBE_W'(MAX_PRB)) ? MAX_PRB : 32'(cfg_probes);
        mask = (HASH_W'(1) << size_eff) - HASH_W'(1);
        r.present = (k.cmd == CMD_QUERY);
        for (int i = 0; i < n_eff; i++) begin
            idx  = (k.lo + k.hi * HASH_W'(i)) & mask;
            word = idx >> WORD_SHIFT;
            if (k.cmd == CMD_ADD)
                filt_bits[word][idx[WORD_SHIFT-1:0]] = 1'b1;
            else if (!filt_bits[word][idx[WORD_SHIFT-1:0]])
                r.present = 1'b0;
        end
        if (k.cmd == CMD_ADD && keys_added != COUNT_MAX)
            keys_added++;
        r.count = keys_added;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    endtask

    // mostly back to back, sometimes a short pause, rarely a long one
    function automatic int unsigned pick_gap(int unsigned idle_pct);
        int unsigned r;
        if (calm)
            return 0;
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [HASH_W-1:0] rand_word();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return '1;
            2: return HASH_W'(1);
            3: return {1'b1, {(HASH_W-1){1'b0}}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    always @(posedge i_clk) begin
        key_beat_t k;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (send_gap > 0) begin
                req_if.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (keys_pending.size() > 0) begin
                k = keys_pending.pop_front();
                req_if.cmd     <= k.cmd;
                req_if.hash_lo <= k.lo;
                req_if.hash_hi <= k.hi;
                req_if.valid   <= 1'b1;
                send_gap       <= pick_gap(45);
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        int unsigned n;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            n = pick_gap(12);
            rsp_if.ready <= (n == 0);
            stall_left   <= (n == 0) ? 0 : n - 1;
        end
    end

    // inputs are predicted before outputs are popped, so the queue front is always the oldest
    always @(posedge i_clk) begin
        key_beat_t      seen;
        lookup_result_t want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                seen.cmd = req_if.cmd;
                seen.lo  = req_if.hash_lo;
                seen.hi  = req_if.hash_hi;
                results_due.push_back(hash_probe(seen));
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result beat with nothing pending",
                                    64'(rsp_if.item_count), 64'(0));
                end else begin
                    want = results_due.pop_front();
                    if (rsp_if.present !== want.present)
                        report_mismatch("present", 64'(rsp_if.present), 64'(want.present));
                    if (rsp_if.item_count !== want.count)
                        report_mismatch("item_count", 64'(rsp_if.item_count),
                                        64'(want.count));
                end
            end
        end
    end

    task automatic cfg_access(input logic wr, input logic reg_idx,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_regs();
        logic [APB_DATA_W-1:0] rd;
        cfg_access(1'b0, REG_SIZE_LOG2, '0, rd);
        if (rd[SIZE_W-1:0] !== cfg_size)
            report_mismatch("size_log2 readback", 64'(rd), 64'(cfg_size));
        cfg_access(1'b0, REG_PROBE_COUNT, '0, rd);
        if (rd[PROBE_W-1:0] !== cfg_probes)
            report_mismatch("probe_count readback", 64'(rd), 64'(cfg_probes));
    endtask

    task automatic set_filter(input logic [SIZE_W-1:0] size, input logic [PROBE_W-1:0] probes);
        logic [APB_DATA_W-1:0] rd;
        cfg_access(1'b1, REG_SIZE_LOG2, APB_DATA_W'(size), rd);
        cfg_size = size;
        cfg_access(1'b1, REG_PROBE_COUNT, APB_DATA_W'(probes), rd);
        cfg_probes = probes;
        check_regs();
    endtask

    task automatic push_key(input logic cmd, input logic [HASH_W-1:0] lo,
                            input logic [HASH_W-1:0] hi);
        key_beat_t k;
        k.cmd = cmd;
        k.lo  = lo;
        k.hi  = hi;
        keys_pending.push_back(k);
        if (cmd == CMD_ADD) begin
            keys_kept.push_back(k);
            if (keys_kept.size() > KEEP_KEYS)
                void'(keys_kept.pop_front());
        end
    endtask

    // sampled at the falling edge so that all of the rising edge's updates have landed
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (keys_pending.size() != 0 || req_if.valid || results_due.size() != 0);
    endtask

    initial begin
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        key_beat_t         k;
        int                issued;
        int                burst;
        int unsigned       r;

        foreach (filt_bits[i])
            filt_bits[i] = '0;
        keys_added     = '0;
        cfg_size       = SIZE_RESET;
        cfg_probes     = PROBE_RESET;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_if.valid   = 1'b0;
        req_if.cmd     = CMD_ADD;
        req_if.hash_lo = '0;
        req_if.hash_hi = '0;
        rsp_if.ready   = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: empty store, stride zero, index wrap
        check_regs();
        push_key(CMD_QUERY, '0, '0);
        push_key(CMD_ADD, '0, '0);
        push_key(CMD_QUERY, '0, '0);
        push_key(CMD_ADD, '1, '1);
        push_key(CMD_QUERY, '1, '1);
        push_key(CMD_QUERY, HASH_W'(512), '0);
        push_key(CMD_QUERY, HASH_W'(1), '0);
        push_key(CMD_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        push_key(CMD_QUERY, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        push_key(CMD_QUERY, 64'h123, 64'h40);
        wait_idle();

        // size below range, zero probes
        set_filter('0, '0);
        push_key(CMD_QUERY, rand_word(), rand_word());
        push_key(CMD_ADD, rand_word(), rand_word());
        wait_idle();

        // size and probe count above range
        set_filter('1, '1);
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        push_key(CMD_ADD, a, b);
        push_key(CMD_QUERY, a, b);
        push_key(CMD_QUERY, ~a, b);
        push_key(CMD_ADD, '0, HASH_W'(1));
        push_key(CMD_QUERY, HASH_W'(5), HASH_W'(1));
        wait_idle();

        set_filter(SIZE_W'(16), PROBE_W'(1));
        push_key(CMD_ADD, 64'hFFFF, '0);
        push_key(CMD_QUERY, 64'h1_FFFF, '0);
        wait_idle();

        // shrink without clearing: old bits seen through the new mask
        set_filter(SIZE_W'(9), PROBE_W'(32));
        push_key(CMD_QUERY, 64'h1FF, '0);
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        push_key(CMD_ADD, a, b);
        push_key(CMD_QUERY, a, b);
        wait_idle();

        issued = 0;
        while (issued < TARGET_ITEMS) begin
            r = $urandom_range(0, 9);
            if (r == 0)
                cfg_size = SIZE_W'($urandom_range(0, MIN_SIZE_LOG2 - 1));
            else if (r == 1)
                cfg_size = SIZE_W'($urandom_range(MAX_LOG2 + 1, 31));
            else
                cfg_size = SIZE_W'($urandom_range(MIN_SIZE_LOG2, MAX_LOG2));
            r = $urandom_range(0, 9);
            if (r == 0)
                cfg_probes = '0;
            else if (r == 1)
                cfg_probes = PROBE_W'($urandom_range(MAX_PRB + 1, 63));
            else if (r == 2)
                cfg_probes = PROBE_W'(MAX_PRB);
            else
                cfg_probes = PROBE_W'($urandom_range(1, 10));
            set_filter(cfg_size, cfg_probes);
            calm = ($urandom_range(0, 3) == 0);

            burst = $urandom_range(40, 80);
            if (burst > TARGET_ITEMS - issued)
                burst = TARGET_ITEMS - issued;
            for (int n = 0; n < burst; n++) begin
                r = $urandom_range(0, 99);
                if (r < 40 || keys_kept.size() == 0) begin
                    push_key(CMD_ADD, rand_word(), rand_word());
                end else if (r < 75) begin
                    k = keys_kept[$urandom_range(0, keys_kept.size() - 1)];
                    push_key(CMD_QUERY, k.lo, k.hi);
                end else if (r < 85) begin
                    // near miss: a known key with one base bit flipped
                    k = keys_kept[$urandom_range(0, keys_kept.size() - 1)];
                    push_key(CMD_QUERY, k.lo ^ (HASH_W'(1) << $urandom_range(0, 15)), k.hi);
                end else begin
                    push_key(CMD_QUERY, rand_word(), rand_word());
                end
                issued++;
            end
            wait_idle();
        end

        calm = 1'b0;
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: bloom_filter_double_hash.f
sv/bfdh_pkg.sv
sv/bfdh_req_if.sv
sv/bfdh_rsp_if.sv
sv/bfdh_ram.sv
sv/bloom_filter_double_hash.sv
verif/tb.sv
